// ----- sv/sclfp_pkg.sv -----
package sclfp_pkg;

  // Largest payload a frame may carry; longer length bytes are clamped to it.
  localparam int MaxPayload = 32;

  // Value of the start byte register after reset.
  localparam logic [7:0] StartByteReset = 8'h55;

  // Parser phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  // One result item as it waits in the output or skid register.
  typedef struct packed {
    logic       frame_ready;
    logic       frame_done;
    logic [7:0] cmd_value;
    logic [5:0] length_value;
    logic       payload_valid;
    logic [4:0] payload_index;
    logic [7:0] payload_byte;
  } result_t;

endpackage

// ----- sv/sync_cmd_length_frame_parser.sv -----
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid / cfg_ready     cfg_data (start byte)
// in        in         in_valid / in_stall       rx_byte
// out       out        out_valid / out_stall     frame_ready .. payload_byte
//
// The parser state is updated on the edge that accepts a byte, and its result is
// written into the output register then, or into the skid register if that is held.
// A skid register holds one extra result, so in_stall is a register output and
// rises only once both the output and the skid register are full.
// Synchronous reset sets the phase to idle, clears the counters and flags, and
// reloads the start byte register with 0x55.
module sync_cmd_length_frame_parser
  import sclfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       frame_ready,
  output logic       frame_done,
  output logic [7:0] cmd_value,
  output logic [5:0] length_value,
  output logic       payload_valid,
  output logic [4:0] payload_index,
  output logic [7:0] payload_byte
);

  localparam logic [7:0] MaxLen = 8'(MaxPayload);

  logic [7:0] sof_value;
  logic [1:0] phase, phase_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] frame_cmd, frame_cmd_next;
  logic [7:0] frame_length, frame_length_next;
  logic       ready_flag, ready_flag_next;

  result_t    res, out_reg, skid_reg;
  logic       skid_full;
  logic       take, out_free;
  logic [8:0] count_inc;
  logic [7:0] clamped;
  logic       done, pvalid;
  logic [7:0] pindex;
  logic [7:0] pbyte;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign take      = in_valid && !skid_full;
  assign out_free  = !out_valid || !out_stall;

  // Start byte register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sof_value <= StartByteReset;
    end else if (cfg_valid && cfg_ready) begin
      sof_value <= cfg_data;
    end
  end

  // Next parser state and result for the byte on the input.
  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    frame_cmd_next     = frame_cmd;
    frame_length_next  = frame_length;
    ready_flag_next    = ready_flag;
    done               = 1'b0;
    pvalid             = 1'b0;
    pindex             = 8'd0;
    pbyte              = 8'd0;
    clamped            = (rx_byte > MaxLen) ? MaxLen : rx_byte;
    count_inc          = {1'b0, payload_count};
    case (phase)
      PH_IDLE: begin
        if (rx_byte == sof_value) begin
          payload_count_next = 8'd0;
          phase_next         = PH_CMD;
          ready_flag_next    = 1'b0;
        end
      end
      PH_CMD: begin
        if (rx_byte != sof_value) begin
          frame_cmd_next = rx_byte;
          phase_next     = PH_LEN;
        end
      end
      PH_LEN: begin
        frame_length_next = clamped;
        if (clamped == 8'd0) begin
          payload_count_next = 8'd0;
          phase_next         = PH_IDLE;
          ready_flag_next    = 1'b1;
          done               = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      default: begin
        // Payload byte: emit it with its index, finish when the count is reached.
        if (payload_count < frame_length) begin
          pvalid    = 1'b1;
          pindex    = payload_count;
          pbyte     = rx_byte;
          count_inc = {1'b0, payload_count} + 9'd1;
        end
        payload_count_next = count_inc[7:0];
        if (count_inc >= {1'b0, frame_length} || count_inc >= {1'b0, MaxLen}) begin
          phase_next         = PH_IDLE;
          payload_count_next = 8'd0;
          ready_flag_next    = 1'b1;
          done               = 1'b1;
        end
      end
    endcase

    res.frame_ready   = ready_flag_next;
    res.frame_done    = done;
    res.cmd_value     = frame_cmd_next;
    res.length_value  = frame_length_next[5:0];
    res.payload_valid = pvalid;
    res.payload_index = pindex[4:0];
    res.payload_byte  = pbyte;
  end

  // Parser state, updated once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      payload_count <= 8'd0;
      frame_cmd     <= 8'd0;
      frame_length  <= 8'd0;
      ready_flag    <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      frame_cmd     <= frame_cmd_next;
      frame_length  <= frame_length_next;
      ready_flag    <= ready_flag_next;
    end
  end

  // Output register with a one-entry skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (take) begin
      if (out_free) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_reg  <= res;
        skid_full <= 1'b1;
      end
    end else if (out_free) begin
      if (skid_full) begin
        out_reg   <= skid_reg;
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign frame_ready   = out_reg.frame_ready;
  assign frame_done    = out_reg.frame_done;
  assign cmd_value     = out_reg.cmd_value;
  assign length_value  = out_reg.length_value;
  assign payload_valid = out_reg.payload_valid;
  assign payload_index = out_reg.payload_index;
  assign payload_byte  = out_reg.payload_byte;

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sclfp_pkg::*;

  // Cycles without any accepted transaction before the run is abandoned.
  localparam int StallLimit = 2000;
  localparam int DirRows = 16;

  // One row of the directed sequence. When check_typed is set, typed_res is
  // the result read off by hand; otherwise the predictor supplies it.
  typedef struct {
    logic [7:0] rx;
    bit         check_typed;
    result_t    typed_res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       frame_ready;
  logic       frame_done;
  logic [7:0] cmd_value;
  logic [5:0] length_value;
  logic       payload_valid;
  logic [4:0] payload_index;
  logic [7:0] payload_byte;

  // Parser state as the predictor tracks it, starting from its reset values.
  logic [1:0]  parse_phase = PH_IDLE;
  int unsigned taken_count = 0;
  int unsigned latched_len = 0;
  logic [7:0]  latched_cmd = 8'h00;
  bit          ready_sticky = 1'b0;
  logic [7:0]  start_value = StartByteReset;

  result_t results_due[$];
  int      fail_count = 0;
  int      bytes_sent = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  bit      quiet = 1'b0;

  // Field order in each result: ready, done, cmd, length, valid, index, byte.
  dir_row_t dir_rows [DirRows] = '{
    '{8'h00, 1'b1, {1'b0, 1'b0, 8'h00, 6'd0, 1'b0, 5'd0, 8'h00}},
    '{8'h55, 1'b1, {1'b0, 1'b0, 8'h00, 6'd0, 1'b0, 5'd0, 8'h00}},
    '{8'h55, 1'b1, {1'b0, 1'b0, 8'h00, 6'd0, 1'b0, 5'd0, 8'h00}},
    '{8'hFF, 1'b1, {1'b0, 1'b0, 8'hFF, 6'd0, 1'b0, 5'd0, 8'h00}},
    '{8'h00, 1'b1, {1'b1, 1'b1, 8'hFF, 6'd0, 1'b0, 5'd0, 8'h00}},
    '{8'h12, 1'b1, {1'b1, 1'b0, 8'hFF, 6'd0, 1'b0, 5'd0, 8'h00}},
    '{8'h55, 1'b1, {1'b0, 1'b0, 8'hFF, 6'd0, 1'b0, 5'd0, 8'h00}},
    '{8'h00, 1'b1, {1'b0, 1'b0, 8'h00, 6'd0, 1'b0, 5'd0, 8'h00}},
    '{8'h02, 1'b1, {1'b0, 1'b0, 8'h00, 6'd2, 1'b0, 5'd0, 8'h00}},
    '{8'h55, 1'b1, {1'b0, 1'b0, 8'h00, 6'd2, 1'b1, 5'd0, 8'h55}},
    '{8'hFF, 1'b1, {1'b1, 1'b1, 8'h00, 6'd2, 1'b1, 5'd1, 8'hFF}},
    '{8'h55, 1'b1, {1'b0, 1'b0, 8'h00, 6'd2, 1'b0, 5'd0, 8'h00}},
    '{8'hA5, 1'b1, {1'b0, 1'b0, 8'hA5, 6'd2, 1'b0, 5'd0, 8'h00}},
    '{8'h55, 1'b1, {1'b0, 1'b0, 8'hA5, 6'd32, 1'b0, 5'd0, 8'h00}},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}
  };

  sync_cmd_length_frame_parser uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_ready  (frame_ready),
    .frame_done   (frame_done),
    .cmd_value    (cmd_value),
    .length_value (length_value),
    .payload_valid(payload_valid),
    .payload_index(payload_index),
    .payload_byte (payload_byte)
  );

  always #5 clk = ~clk;

  // Advances the predicted parser state by one byte and returns its result.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (parse_phase)
      PH_IDLE: begin
        if (b == start_value) begin
          taken_count = 0;
          parse_phase = PH_CMD;
          ready_sticky = 1'b0;
        end
      end
      PH_CMD: begin
        if (b != start_value) begin
          latched_cmd = b;
          parse_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        latched_len = (b > MaxPayload) ? MaxPayload : b;
        if (latched_len == 0) begin
          taken_count = 0;
          parse_phase = PH_IDLE;
          ready_sticky = 1'b1;
          r.frame_done = 1'b1;
        end else begin
          parse_phase = PH_DATA;
        end
      end
      default: begin
        if (taken_count < latched_len) begin
          r.payload_valid = 1'b1;
          r.payload_index = taken_count[4:0];
          r.payload_byte = b;
          taken_count++;
        end
        if (taken_count >= latched_len || taken_count >= MaxPayload) begin
          parse_phase = PH_IDLE;
          taken_count = 0;
          ready_sticky = 1'b1;
          r.frame_done = 1'b1;
        end
      end
    endcase
    r.frame_ready = ready_sticky;
    r.cmd_value = latched_cmd;
    r.length_value = latched_len[5:0];
    return r;
  endfunction

  // Random idle length for either side, drawn from one of two ranges.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one byte, waits for the transaction and records its expected result.
  task automatic offer_rx(input logic [7:0] b, input bit check_typed = 1'b0,
                          input result_t typed_res = '0);
    int gap;
    result_t r;
    gap = (!quiet && $urandom_range(0, 99) < 20) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = parse_byte(b);
    results_due.push_back(check_typed ? typed_res : r);
    bytes_sent++;
  endtask

  // Stops offering bytes and waits until every expected result has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Writes the start byte register while the block has nothing in flight.
  task automatic write_sof(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    start_value = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, mixed with truncated
  // frames and stray bytes.
  task automatic send_frames(input int amount);
    int goal;
    int pick;
    int len;
    int body;
    goal = bytes_sent + amount;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 99) < 78) begin
        offer_rx(start_value);
        if ($urandom_range(0, 9) == 0) offer_rx(start_value);
        offer_rx(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 15) len = 0;
        else if (pick < 60) len = $urandom_range(1, 6);
        else if (pick < 75) len = $urandom_range(7, 29);
        else if (pick < 90) len = $urandom_range(30, 33);
        else len = $urandom_range(34, 255);
        offer_rx(8'(len));
        body = (len > MaxPayload) ? MaxPayload : len;
        if ($urandom_range(0, 9) == 0) body = $urandom_range(0, body);
        for (int i = 0; i < body; i++) begin
          offer_rx(($urandom_range(0, 6) == 0) ? start_value : 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) offer_rx(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver side: random stall stretches, no new ones started while in a quiet phase.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!rst && !quiet && $urandom_range(0, 99) < 15) stall_left <= pick_gap();
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      seen = {frame_ready, frame_done, cmd_value, length_value,
              payload_valid, payload_index, payload_byte};
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: result with no expectation waiting", $realtime);
      end else begin
        want = results_due.pop_front();
        if (seen.frame_ready !== want.frame_ready || seen.frame_done !== want.frame_done ||
            seen.cmd_value !== want.cmd_value || seen.length_value !== want.length_value ||
            seen.payload_valid !== want.payload_valid ||
            seen.payload_index !== want.payload_index ||
            seen.payload_byte !== want.payload_byte) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: mismatch exp rdy=%b done=%b cmd=%h len=%0d pv=%b idx=%0d byte=%h",
                     $realtime, want.frame_ready, want.frame_done, want.cmd_value,
                     want.length_value, want.payload_valid, want.payload_index,
                     want.payload_byte);
            $display("%0t:          got rdy=%b done=%b cmd=%h len=%0d pv=%b idx=%0d byte=%h",
                     $realtime, seen.frame_ready, seen.frame_done, seen.cmd_value,
                     seen.length_value, seen.payload_valid, seen.payload_index,
                     seen.payload_byte);
          end
        end
      end
    end
  end

  // Watchdog: any accepted transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sequence with the start byte at its reset value.
    foreach (dir_rows[i]) offer_rx(dir_rows[i].rx, dir_rows[i].check_typed,
                                   dir_rows[i].typed_res);
    send_frames(300);

    // Random phases over several start byte settings, the extremes included.
    write_sof(8'h00);
    quiet = 1'b1;
    send_frames(300);
    write_sof(8'hFF);
    quiet = 1'b0;
    send_frames(300);
    write_sof(8'($urandom_range(0, 255)));
    send_frames(200);
    write_sof(StartByteReset);
    quiet = 1'b1;
    send_frames(200);

    drain();
    repeat (5) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
